/* rtl/core/srpc_pkg.sv */
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and constants of the record parser with CRC-32 check.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int unsigned REC_LEN    = 93;
  localparam int unsigned CRC_LEN    = 89;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CORRUPT     = 2'd1,
    ST_BAD_VERSION = 2'd2
  } rec_status_t;

  typedef enum logic [2:0] {
    FID_HASH      = 3'd0,
    FID_HEIGHT    = 3'd1,
    FID_WORK      = 3'd2,
    FID_TIMESTAMP = 3'd3,
    FID_IDLE      = 3'd4,
    FID_FLUSH     = 3'd5
  } field_id_t;

  typedef struct packed {
    logic        is_status;
    field_id_t   field_id;
    logic [1:0]  word_index;
    logic [63:0] field_value;
    rec_status_t record_status;
  } result_t;

endpackage

/* rtl/core/state_record_parser_crc32_check.sv */
// ----------------------------------------------------------------------------
// state_record_parser_crc32_check
// Fixed 93-byte record parser with field extraction and CRC-32 check.
// ----------------------------------------------------------------------------
// The input stream carries one record byte per word, with tlast on the final
// byte. Each field word is sent on the output stream as soon as it completes
// (tuser low), and the word with tlast ends the record with a status word
// (tuser high). The consumer keeps field words only if the status is ok.
// Magic and version registers are written through the cfg port, and the user
// must write them only while idle; the block itself does not enforce it.
// An input word is taken every cycle while the four-entry result queue has
// room; words that complete no field produce no output. An accepted word's
// result is written into the queue and loaded into the output register
// once that register is free. When the receiver stalls, results collect in
// the queue and tready falls once it is full.
// Synchronous reset clears the record state, the queue, the output valid and
// both configuration registers.
// ----------------------------------------------------------------------------
module state_record_parser_crc32_check #(
  parameter int unsigned FIFO_DEPTH = srpc_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [srpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [2:0] field_id, [4:3] word_index, [68:5] field_value,
  // [70:69] record_status, [71] zero
  output logic [71:0]                    m_tdata,
  output logic                           m_tuser    // is_status
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH+1);

  logic              accept;
  logic              push;
  srpc_pkg::result_t push_data;
  logic              pop;
  srpc_pkg::result_t pop_data;
  logic              q_empty;
  logic              q_full;
  logic [CNT_W-1:0]  q_count;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  srpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_byte     (s_tdata),
    .end_of_record (s_tlast),
    .push          (push),
    .result        (push_data)
  );

  srpc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  srpc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("result pushed into a full queue");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[68:0] == 69'd0)
    else $error("status word carries field data");

  a_field_id_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[2:0] <= 3'd5 && m_tdata[70:69] == 2'd0)
    else $error("field word with bad id or nonzero status");
`endif

endmodule

/* rtl/core/srpc_front.sv */
// ----------------------------------------------------------------------------
// srpc_front
// Takes record bytes, tracks position and CRC, and classifies each byte.
// ----------------------------------------------------------------------------
module srpc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [srpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srpc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_record,
  output logic                            push,
  output srpc_pkg::result_t               result
);

  logic [31:0]                  magic_word;
  logic [31:0]                  version_word;
  logic [srpc_pkg::POS_W-1:0]   byte_position;
  logic [31:0]                  crc_register;
  logic [63:0]                  assembly_shift;
  logic                         magic_bad;
  logic                         version_bad;

  logic [srpc_pkg::POS_W-1:0]   byte_position_next;
  logic [31:0]                  crc_register_next;
  logic [63:0]                  assembly_shift_next;
  logic                         magic_bad_next;
  logic                         version_bad_next;
  logic                         have_field;
  srpc_pkg::field_id_t          fid;
  logic [1:0]                   widx;
  logic [63:0]                  fval;
  srpc_pkg::rec_status_t        status;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? srpc_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word   <= '0;
      version_word <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        srpc_pkg::REG_MAGIC:   magic_word   <= cfg_data;
        srpc_pkg::REG_VERSION: version_word <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                       live;
    logic [srpc_pkg::POS_W-1:0] p;
    logic [srpc_pkg::POS_W-1:0] p_hash;
    logic [srpc_pkg::POS_W-1:0] p_work;
    p                   = byte_position;
    live                = (byte_position < srpc_pkg::POS_W'(srpc_pkg::REC_LEN));
    p_hash              = p - srpc_pkg::POS_W'(8);
    p_work              = p - srpc_pkg::POS_W'(44);
    byte_position_next  = byte_position;
    crc_register_next   = crc_register;
    assembly_shift_next = assembly_shift;
    magic_bad_next      = magic_bad;
    version_bad_next    = version_bad;
    have_field          = 1'b0;
    fid                 = srpc_pkg::FID_HASH;
    widx                = 2'd0;
    fval                = 64'd0;
    if (live) begin
      assembly_shift_next = {assembly_shift[55:0], data_byte};
      byte_position_next  = p + srpc_pkg::POS_W'(1);
      if (p < srpc_pkg::POS_W'(srpc_pkg::CRC_LEN)) begin
        crc_register_next = crc_byte(crc_register, data_byte);
      end
      if (p == srpc_pkg::POS_W'(3)) begin
        magic_bad_next = (assembly_shift_next[31:0] != magic_word);
      end else if (p == srpc_pkg::POS_W'(7)) begin
        version_bad_next = (assembly_shift_next[31:0] != version_word);
      end else if (p >= srpc_pkg::POS_W'(8) && p <= srpc_pkg::POS_W'(39)
                   && p_hash[2:0] == 3'd7) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_HASH;
        widx       = p_hash[4:3];
        fval       = assembly_shift_next;
      end else if (p == srpc_pkg::POS_W'(43)) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_HEIGHT;
        fval       = {32'd0, assembly_shift_next[31:0]};
      end else if (p >= srpc_pkg::POS_W'(44) && p <= srpc_pkg::POS_W'(75)
                   && p_work[2:0] == 3'd7) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_WORK;
        widx       = p_work[4:3];
        fval       = assembly_shift_next;
      end else if (p == srpc_pkg::POS_W'(79)) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_TIMESTAMP;
        fval       = {32'd0, assembly_shift_next[31:0]};
      end else if (p == srpc_pkg::POS_W'(80)) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_IDLE;
        fval       = {63'd0, (data_byte != 8'd0)};
      end else if (p == srpc_pkg::POS_W'(88)) begin
        have_field = 1'b1;
        fid        = srpc_pkg::FID_FLUSH;
        fval       = assembly_shift_next;
      end
    end

    if (byte_position_next < srpc_pkg::POS_W'(srpc_pkg::REC_LEN)) begin
      status = srpc_pkg::ST_CORRUPT;
    end else if (magic_bad_next) begin
      status = srpc_pkg::ST_CORRUPT;
    end else if (version_bad_next) begin
      status = srpc_pkg::ST_BAD_VERSION;
    end else if (assembly_shift_next[31:0] != ~crc_register_next) begin
      status = srpc_pkg::ST_CORRUPT;
    end else begin
      status = srpc_pkg::ST_OK;
    end
  end

  always_comb begin
    push   = accept && (end_of_record || have_field);
    result = '0;
    if (end_of_record) begin
      result.is_status     = 1'b1;
      result.field_id      = srpc_pkg::FID_HASH;
      result.record_status = status;
    end else begin
      result.field_id      = fid;
      result.word_index    = widx;
      result.field_value   = fval;
      result.record_status = srpc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      crc_register   <= srpc_pkg::ALL_ONES;
      assembly_shift <= '0;
      magic_bad      <= 1'b0;
      version_bad    <= 1'b0;
    end else if (accept) begin
      if (end_of_record) begin
        byte_position  <= '0;
        crc_register   <= srpc_pkg::ALL_ONES;
        assembly_shift <= '0;
        magic_bad      <= 1'b0;
        version_bad    <= 1'b0;
      end else begin
        byte_position  <= byte_position_next;
        crc_register   <= crc_register_next;
        assembly_shift <= assembly_shift_next;
        magic_bad      <= magic_bad_next;
        version_bad    <= version_bad_next;
      end
    end
  end

endmodule

/* rtl/core/srpc_fifo.sv */
// ----------------------------------------------------------------------------
// srpc_fifo
// Short queue of parsed results between the front and the output stage.
// ----------------------------------------------------------------------------
module srpc_fifo #(
  parameter int unsigned DEPTH = srpc_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  srpc_pkg::result_t push_data,
  input  logic              pop,
  output srpc_pkg::result_t pop_data,
  output logic              empty,
  output logic              full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  srpc_pkg::result_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               do_push;
  logic               do_pop;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/srpc_out.sv */
// ----------------------------------------------------------------------------
// srpc_out
// Output register that packs queued results onto the result stream.
// ----------------------------------------------------------------------------
module srpc_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  srpc_pkg::result_t q_data,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata,
  output logic              m_tuser
);

  srpc_pkg::result_t held;

  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held <= q_data;
    end
  end

  assign m_tuser = held.is_status;
  assign m_tdata = {1'b0, held.record_status, held.field_value,
                    held.word_index, held.field_id};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 93-byte record parser with CRC-32 check.
// ----------------------------------------------------------------------------
// A directed table covers the byte extremes and short records, one of them
// ending on the byte that completes a hash word. Randomly filled records then
// follow: good ones, a bad magic, a bad version, both bad, a CRC mismatch,
// short, overlong and noise. Each accepted byte runs through a local parser
// model, and every field or status word is checked against it in order.
// The magic and version registers change between phases, with both extremes
// used. Both stream sides idle at random, and the output side is held off
// for a long stretch once so that the result queue fills up.
// ----------------------------------------------------------------------------
module testbench;
  import srpc_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 150;
  localparam int NUM_PHASES    = 4;
  localparam int DIR_ROWS_N    = 20;

  typedef enum int {
    RK_GOOD, RK_BAD_MAGIC, RK_BAD_VERSION, RK_BAD_BOTH, RK_BAD_CRC,
    RK_SHORT, RK_LONG, RK_NOISE, RK_COUNT
  } rec_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    res;
  } dir_row_t;

  localparam result_t NO_WORD = '0;
  localparam result_t CORRUPT_WORD = '{is_status: 1'b1, field_id: FID_HASH,
    word_index: 2'd0, field_value: 64'd0, record_status: ST_CORRUPT};

  // A record cut short on the byte that completes the first hash word
  // yields only the status.
  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{8'h00, 1'b1, 1'b1, CORRUPT_WORD},
    '{8'hFF, 1'b1, 1'b1, CORRUPT_WORD},
    '{8'hA5, 1'b0, 1'b0, NO_WORD},
    '{8'h5A, 1'b1, 1'b1, CORRUPT_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'h23, 1'b0, 1'b0, NO_WORD},
    '{8'h45, 1'b0, 1'b0, NO_WORD},
    '{8'h67, 1'b0, 1'b0, NO_WORD},
    '{8'h89, 1'b0, 1'b0, NO_WORD},
    '{8'hAB, 1'b0, 1'b0, NO_WORD},
    '{8'hCD, 1'b0, 1'b0, NO_WORD},
    '{8'hEF, 1'b1, 1'b1, CORRUPT_WORD}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;
  logic                 m_tuser;

  state_record_parser_crc32_check u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state and its copy of the registers.
  logic [31:0] magic_cfg;
  logic [31:0] version_cfg;
  int          rec_pos;
  logic [31:0] crc_acc;
  logic [63:0] shift_reg;
  logic        magic_mismatch;
  logic        version_mismatch;

  result_t pending_words [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  int      hold_requests = 0;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] x;
    x = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic void clear_record();
    rec_pos = 0;
    crc_acc = ALL_ONES;
    shift_reg = '0;
    magic_mismatch = 1'b0;
    version_mismatch = 1'b0;
  endfunction

  function automatic bit parse_record_byte(input logic [7:0] d, input logic l,
                                           output result_t r);
    bit   have;
    int   p;
    logic [31:0] low4;
    r = '0;
    have = 1'b0;
    if (rec_pos < REC_LEN) begin
      p = rec_pos;
      shift_reg = {shift_reg[55:0], d};
      low4 = shift_reg[31:0];
      if (p < CRC_LEN) crc_acc = crc_next(crc_acc, d);
      if (p == 3) begin
        magic_mismatch = (low4 != magic_cfg);
      end else if (p == 7) begin
        version_mismatch = (low4 != version_cfg);
      end else if (p >= 8 && p <= 39 && (p - 8) % 8 == 7) begin
        have = 1'b1;
        r.field_id = FID_HASH;
        r.word_index = 2'((p - 8) / 8);
        r.field_value = shift_reg;
      end else if (p == 43) begin
        have = 1'b1;
        r.field_id = FID_HEIGHT;
        r.field_value = {32'd0, low4};
      end else if (p >= 44 && p <= 75 && (p - 44) % 8 == 7) begin
        have = 1'b1;
        r.field_id = FID_WORK;
        r.word_index = 2'((p - 44) / 8);
        r.field_value = shift_reg;
      end else if (p == 79) begin
        have = 1'b1;
        r.field_id = FID_TIMESTAMP;
        r.field_value = {32'd0, low4};
      end else if (p == 80) begin
        have = 1'b1;
        r.field_id = FID_IDLE;
        r.field_value = (d != 8'd0) ? 64'd1 : 64'd0;
      end else if (p == 88) begin
        have = 1'b1;
        r.field_id = FID_FLUSH;
        r.field_value = shift_reg;
      end
      rec_pos = p + 1;
    end
    if (l) begin
      r = '0;
      r.is_status = 1'b1;
      if (rec_pos < REC_LEN || magic_mismatch) r.record_status = ST_CORRUPT;
      else if (version_mismatch) r.record_status = ST_BAD_VERSION;
      else if (shift_reg[31:0] != ~crc_acc) r.record_status = ST_CORRUPT;
      else r.record_status = ST_OK;
      have = 1'b1;
      clear_record();
    end
    return have;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [31:0] version);
    cfg_wen <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_data <= magic;
    @(posedge clk);
    cfg_index <= REG_VERSION;
    cfg_data <= version;
    @(posedge clk);
    cfg_wen <= 1'b0;
    magic_cfg = magic;
    version_cfg = version;
  endtask

  task automatic send_word(input logic [7:0] d, input logic l, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    int      n;
    bit      have;
    result_t r;
    n = pick_gap(tx_quiet);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    have = parse_record_byte(d, l, r);
    if (typed) pending_words = {pending_words, typed_res};
    else if (have) pending_words = {pending_words, r};
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_record(input rec_kind_t kind, output int sent);
    logic [7:0]  rec [REC_LEN];
    logic [31:0] crc;
    int          len;
    for (int i = 0; i < REC_LEN; i++) rec[i] = 8'($urandom);
    {rec[0], rec[1], rec[2], rec[3]} = magic_cfg;
    {rec[4], rec[5], rec[6], rec[7]} = version_cfg;
    if ($urandom_range(0, 2) == 0) rec[80] = 8'd0;
    if (kind == RK_BAD_MAGIC || kind == RK_BAD_BOTH) begin
      len = $urandom_range(0, 3);
      rec[len] = rec[len] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (kind == RK_BAD_VERSION || kind == RK_BAD_BOTH) begin
      len = $urandom_range(4, 7);
      rec[len] = rec[len] ^ (8'h01 << $urandom_range(0, 7));
    end
    crc = ALL_ONES;
    for (int i = 0; i < CRC_LEN; i++) crc = crc_next(crc, rec[i]);
    {rec[89], rec[90], rec[91], rec[92]} = ~crc;
    if (kind == RK_BAD_CRC) begin
      len = $urandom_range(8, REC_LEN - 1);
      rec[len] = rec[len] ^ (8'h01 << $urandom_range(0, 7));
    end
    case (kind)
      RK_SHORT: len = $urandom_range(1, REC_LEN - 1);
      RK_LONG:  len = REC_LEN + $urandom_range(1, 8);
      RK_NOISE: len = $urandom_range(1, 40);
      default:  len = REC_LEN;
    endcase
    for (int i = 0; i < len; i++) begin
      if (kind == RK_NOISE) begin
        send_word(8'($urandom), (i == len - 1) || ($urandom_range(0, 15) == 0));
      end else begin
        send_word((i < REC_LEN) ? rec[i] : 8'($urandom), i == len - 1);
      end
    end
    sent = len;
  endtask

  function automatic rec_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return RK_GOOD;
    if (r < 52) return RK_BAD_MAGIC;
    if (r < 59) return RK_BAD_VERSION;
    if (r < 63) return RK_BAD_BOTH;
    if (r < 72) return RK_BAD_CRC;
    if (r < 86) return RK_SHORT;
    if (r < 94) return RK_LONG;
    return RK_NOISE;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word data %h user %b", m_tdata, m_tuser));
      end else begin
        want = pending_words.pop_front();
        compare_field("is_status", 64'(m_tuser), 64'(want.is_status));
        compare_field("field_id", 64'(m_tdata[2:0]), 64'(want.field_id));
        compare_field("word_index", 64'(m_tdata[4:3]), 64'(want.word_index));
        compare_field("field_value", m_tdata[68:5], want.field_value);
        compare_field("record_status", 64'(m_tdata[70:69]), 64'(want.record_status));
      end
    end
  end

  initial begin : result_sink
    int stall;
    int holds_done;
    stall = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall = 0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap(rx_quiet);
      end
    end
  end

  initial begin : stimulus
    int        sent;
    int        phase_bytes;
    int        rec_count;
    rec_kind_t kind;
    rec_count = 0;
    clear_record();
    magic_cfg = '0;
    version_cfg = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_config(32'h0, 32'h0);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      send_word(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       set_config(32'h0, 32'h0);
        1:       set_config(ALL_ONES, ALL_ONES);
        2:       set_config($urandom, $urandom);
        default: set_config($urandom, 32'h0);
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        kind = (rec_count < RK_COUNT) ? rec_kind_t'(rec_count) : pick_kind();
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if (ph == 1 && phase_bytes == 0) begin
          hold_requests++;
          tx_quiet = 1'b1;
          kind = RK_GOOD;
        end
        send_record(kind, sent);
        phase_bytes += sent;
        rec_count++;
      end
    end

    settle();
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
